/* hw/rtl/bba_pkg.sv */
// Shared types, constants and helpers for the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned MAX_POOL_ORDER   = 18;
  localparam int unsigned MIN_BLOCK_ORDER  = 5;
  localparam int unsigned POOL_ORDER_FLOOR = 13;
  localparam int unsigned POOL_ORDER_RESET = 18;

  localparam int unsigned OFF_W   = MAX_POOL_ORDER;
  localparam int unsigned SIZE_W  = MAX_POOL_ORDER + 1;
  localparam int unsigned ORD_W   = 5;
  localparam int unsigned GW      = MAX_POOL_ORDER - MIN_BLOCK_ORDER;
  localparam int unsigned CW      = GW + 1;
  localparam int unsigned DEPTH   = 1 << GW;
  localparam int unsigned ENT_W   = 7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_TOOBIG  = 2'd2,
    ST_BADFREE = 2'd3
  } bba_status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bba_cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_EV,
    S_MERGE_RD,
    S_MERGE_EV,
    S_FINAL,
    S_DONE
  } bba_state_e;

  typedef struct packed {
    bba_status_e        status;
    logic [OFF_W-1:0]   offset;
    logic [ORD_W-1:0]   order;
  } bba_result_t;

  // Entry layout: head flag, free flag, block order
  function automatic logic [ENT_W-1:0] mk_entry(input logic free_b, input logic [ORD_W-1:0] ord);
    mk_entry = {1'b1, free_b, ord};
  endfunction

  function automatic logic [ORD_W-1:0] clamp_order(input logic [ORD_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = v;
    if (v < ORD_W'(POOL_ORDER_FLOOR)) r = ORD_W'(POOL_ORDER_FLOOR);
    if (v > ORD_W'(MAX_POOL_ORDER))   r = ORD_W'(MAX_POOL_ORDER);
    clamp_order = r;
  endfunction

  // floor(log2(size)) + 1, raised to the minimum order; zero maps to the minimum
  function automatic logic [ORD_W-1:0] need_order(input logic [SIZE_W-1:0] size);
    logic [ORD_W-1:0] fl;
    logic [ORD_W-1:0] k;
    fl = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size[i]) fl = ORD_W'(i);
    end
    k = ORD_W'(MIN_BLOCK_ORDER);
    if (size != '0 && (fl + ORD_W'(1)) > k) k = fl + ORD_W'(1);
    need_order = k;
  endfunction

endpackage

/* hw/rtl/buddy_block_allocator_core.sv */
// Top level of the buddy block allocator: engine plus output register.
`timescale 1ns / 1ps
// Binary buddy allocator over a pool of 2^pool_order bytes in 32-byte granules.
// Input channel (in_valid_i / in_stall_o) carries one command: allocate with
// request_size_i, or free with free_offset_i. Output channel (out_valid_o /
// out_stall_i) returns one result per command: status, granted offset, order.
// A transfer happens on a rising edge with valid high and stall low.
// Commands are handled one at a time. The granule table is a RAM with one
// read a cycle, so the time from the accepting edge to out_valid_o is set by
// its accesses: a free reads its entry, then reads the buddy once per merge
// step; an allocate reads each table entry visited in the scan, then writes
// one new free half per split step. A size too large or a misaligned or
// out-of-pool free returns without a table access, a free of an entry that
// is no allocated block after reading that entry. The next command is taken
// from the cycle after the result enters the output register.
// After reset, and after each write of pool_order (cfg_we_i / cfg_wdata_i),
// a clearing pass rewrites every table entry, leaving one free block; no
// command is taken meanwhile. pool_order resets to 18 and is clamped to 13..18.
// A result waits in the output register while the receiver stalls; the next
// command is taken meanwhile and its result is held until the register frees.
module buddy_block_allocator_core
  import bba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ORD_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [OFF_W-1:0]  granted_offset_o,
  output logic [ORD_W-1:0]  granted_order_o
);

  logic        res_valid;
  logic        res_ack;
  bba_result_t res;
  logic        out_valid_q;
  bba_result_t out_q;

  bba_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .request_size_i (request_size_i),
    .free_offset_i  (free_offset_i),
    .res_valid_o    (res_valid),
    .res_ack_i      (res_ack),
    .res_o          (res)
  );

  // load when the register is empty or its transfer completes now
  assign res_ack = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) out_q <= res;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign granted_offset_o = out_q.offset;
  assign granted_order_o  = out_q.order;

endmodule

/* hw/rtl/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/bba_engine.sv */
// Sequencer that searches, splits and merges blocks in the granule table.
`timescale 1ns / 1ps
module bba_engine
  import bba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ORD_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  output logic              res_valid_o,
  input  logic              res_ack_i,
  output bba_result_t       res_o
);

  bba_state_e state_q, state_d;

  logic [ORD_W-1:0]  pool_order_q;
  logic              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFF_W-1:0]  off_q;
  logic [ORD_W-1:0]  k_q;
  logic [CW-1:0]     g_q;
  logic [GW-1:0]     best_q;
  logic [ORD_W-1:0]  best_ord_q;
  logic              found_q;
  logic [ORD_W-1:0]  j_q;
  logic [GW-1:0]     l_q;
  logic [CW-1:0]     clr_q;
  bba_result_t       res_q;

  logic              ram_we;
  logic [GW-1:0]     ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [GW-1:0]     ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  logic [CW-1:0]     total;
  logic [ORD_W-1:0]  dec_k;
  logic              free_bad_off;
  logic [ORD_W-1:0]  e_ord;
  logic              e_head_ok;
  logic [CW-1:0]     e_step;
  logic [ORD_W-1:0]  j_dn;
  logic [CW-1:0]     upper;
  logic [GW-1:0]     buddy;
  logic              buddy_match;

  bba_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign total        = CW'(1) << (pool_order_q - ORD_W'(MIN_BLOCK_ORDER));
  assign dec_k        = need_order(size_q);
  assign free_bad_off = (off_q[MIN_BLOCK_ORDER-1:0] != '0) ||
                        ({1'b0, off_q[OFF_W-1:MIN_BLOCK_ORDER]} >= total);
  assign e_ord        = ram_rdata[ORD_W-1:0];
  assign e_head_ok    = ram_rdata[ENT_W-1] && (e_ord >= ORD_W'(MIN_BLOCK_ORDER)) &&
                        (e_ord <= pool_order_q);
  assign e_step       = CW'(1) << (e_ord - ORD_W'(MIN_BLOCK_ORDER));
  assign j_dn         = j_q - ORD_W'(1);
  assign upper        = {1'b0, best_q} + (CW'(1) << (j_dn - ORD_W'(MIN_BLOCK_ORDER)));
  assign buddy        = l_q ^ GW'(CW'(1) << (k_q - ORD_W'(MIN_BLOCK_ORDER)));
  assign buddy_match  = (ram_rdata == mk_entry(1'b1, k_q));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:    if (clr_q == CW'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:     if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        if (cmd_q == CMD_ALLOC) begin
          state_d = (dec_k > pool_order_q) ? S_DONE : S_SCAN_RD;
        end else begin
          state_d = free_bad_off ? S_DONE : S_FREE_RD;
        end
      end
      S_SCAN_RD: begin
        if (g_q >= total) state_d = found_q ? S_SPLIT : S_DONE;
        else              state_d = S_SCAN_EV;
      end
      S_SCAN_EV:  state_d = S_SCAN_RD;
      S_SPLIT:    if (j_q <= k_q) state_d = S_DONE;
      S_FREE_RD:  state_d = S_FREE_EV;
      S_FREE_EV: begin
        if (!e_head_ok || ram_rdata[ENT_W-2]) state_d = S_DONE;
        else                                  state_d = S_MERGE_RD;
      end
      S_MERGE_RD: state_d = (k_q < pool_order_q) ? S_MERGE_EV : S_FINAL;
      S_MERGE_EV: state_d = buddy_match ? S_MERGE_RD : S_FINAL;
      S_FINAL:    state_d = S_DONE;
      S_DONE:     if (res_ack_i) state_d = S_IDLE;
      default:    state_d = S_CLEAR;
    endcase
    if (cfg_we_i) state_d = S_CLEAR;
  end

  // Table access and handshake outputs
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = l_q;
    ram_wdata  = '0;
    ram_raddr  = g_q[GW-1:0];
    in_stall_o = (state_q != S_IDLE);
    res_valid_o = (state_q == S_DONE);
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[GW-1:0];
        ram_wdata = (clr_q == '0) ? mk_entry(1'b1, pool_order_q) : '0;
      end
      S_SPLIT: begin
        if (j_q > k_q) begin
          ram_we    = (upper[CW-1] == 1'b0);
          ram_waddr = upper[GW-1:0];
          ram_wdata = mk_entry(1'b1, j_dn);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = best_q;
          ram_wdata = mk_entry(1'b0, k_q);
        end
      end
      S_FREE_RD:  ram_raddr = l_q;
      S_FREE_EV: begin
        ram_we    = e_head_ok && !ram_rdata[ENT_W-2];
        ram_waddr = l_q;
      end
      S_MERGE_RD: ram_raddr = buddy;
      S_MERGE_EV: begin
        ram_we    = buddy_match;
        ram_waddr = buddy;
      end
      S_FINAL: begin
        ram_we    = 1'b1;
        ram_waddr = l_q;
        ram_wdata = mk_entry(1'b1, k_q);
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      pool_order_q <= clamp_order(ORD_W'(POOL_ORDER_RESET));
      clr_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + CW'(1);
      if (cfg_we_i) begin
        pool_order_q <= clamp_order(cfg_wdata_i);
        clr_q        <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cmd_q  <= command_i;
        size_q <= request_size_i;
        off_q  <= free_offset_i;
        res_q  <= '{status: ST_OK, offset: '0, order: '0};
      end
      S_DECODE: begin
        k_q     <= dec_k;
        g_q     <= '0;
        found_q <= 1'b0;
        l_q     <= off_q[OFF_W-1:MIN_BLOCK_ORDER];
        if (cmd_q == CMD_ALLOC) begin
          if (dec_k > pool_order_q) res_q.status <= ST_TOOBIG;
        end else if (free_bad_off) begin
          res_q.status <= ST_BADFREE;
        end
      end
      S_SCAN_RD: begin
        j_q <= best_ord_q;
        if (g_q >= total && !found_q) res_q.status <= ST_NOSPACE;
      end
      S_SCAN_EV: begin
        if (!e_head_ok) begin
          g_q <= g_q + CW'(1);
        end else begin
          if (ram_rdata[ENT_W-2] && e_ord >= k_q && (!found_q || e_ord < best_ord_q)) begin
            found_q    <= 1'b1;
            best_q     <= g_q[GW-1:0];
            best_ord_q <= e_ord;
          end
          g_q <= g_q + e_step;
        end
      end
      S_SPLIT: begin
        if (j_q > k_q) begin
          j_q <= j_dn;
        end else begin
          res_q.offset <= OFF_W'({best_q, {MIN_BLOCK_ORDER{1'b0}}});
          res_q.order  <= k_q;
        end
      end
      S_FREE_EV: begin
        k_q <= e_ord;
        if (!e_head_ok || ram_rdata[ENT_W-2]) res_q.status <= ST_BADFREE;
      end
      S_MERGE_EV: begin
        if (buddy_match) begin
          k_q <= k_q + ORD_W'(1);
          if (buddy < l_q) l_q <= buddy;
        end
      end
      S_FINAL: begin
        res_q.offset <= OFF_W'({l_q, {MIN_BLOCK_ORDER{1'b0}}});
        res_q.order  <= k_q;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/bba_checker.sv */
// Port-level checks for the buddy block allocator, bound to the top level.
`timescale 1ns / 1ps
module bba_checker
  import bba_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        status_o,
  input logic [OFF_W-1:0]  granted_offset_o,
  input logic [ORD_W-1:0]  granted_order_o
);

  logic [OFF_W:0] align_mask;
  assign align_mask = ((OFF_W+1)'(1) << granted_order_o) - (OFF_W+1)'(1);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_offset_o == '0 && granted_order_o == '0)
    else $error("error result carries nonzero offset or order");

  a_ok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      granted_order_o >= ORD_W'(MIN_BLOCK_ORDER) && granted_order_o <= ORD_W'(MAX_POOL_ORDER))
    else $error("granted order out of range");

  a_ok_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> ({1'b0, granted_offset_o} & align_mask) == '0)
    else $error("granted block not aligned to its size");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(granted_offset_o))
    else $error("stalled result changed");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);

/* tb/sv/buddy_block_allocator_core_tb.sv */
// Self-checking testbench for the buddy block allocator core.
`timescale 1ns / 1ps
module buddy_block_allocator_core_tb;
  import bba_pkg::*;

  typedef struct packed {
    bba_cmd_e          cmd;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
  } alloc_req_t;

  typedef struct packed {
    bba_status_e      status;
    logic [OFF_W-1:0] offset;
    logic [ORD_W-1:0] order;
  } grant_t;

  localparam logic [6:0] HEAD_BIT = 7'h40;
  localparam logic [6:0] FREE_BIT = 7'h20;
  localparam int LIMIT = 100000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ORD_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  logic [SIZE_W-1:0] request_size_i = '0;
  logic [OFF_W-1:0] free_offset_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [OFF_W-1:0] granted_offset_o;
  logic [ORD_W-1:0] granted_order_o;

  buddy_block_allocator_core u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [6:0] granules [DEPTH];
  int unsigned pool_ord;
  int unsigned live_offs [$];

  alloc_req_t pending_reqs [$];
  grant_t expected_grants [$];
  int mismatches = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit cfg_req = 1'b0;
  logic [ORD_W-1:0] cfg_val;

  function automatic void reinit_pool(input int unsigned v);
    pool_ord = (v < POOL_ORDER_FLOOR) ? POOL_ORDER_FLOOR :
               (v > MAX_POOL_ORDER) ? MAX_POOL_ORDER : v;
    foreach (granules[i]) granules[i] = '0;
    granules[0] = HEAD_BIT | FREE_BIT | 7'(pool_ord);
    live_offs.delete();
  endfunction

  function automatic grant_t predict_grant(input alloc_req_t r);
    grant_t g;
    int unsigned k, total, best, best_o, o, idx, j, lo, bud;
    bit found;
    logic [6:0] e;
    g = '{ST_OK, '0, '0};
    total = 1 << (pool_ord - MIN_BLOCK_ORDER);
    if (r.cmd == CMD_ALLOC) begin
      k = MIN_BLOCK_ORDER;
      for (int i = 0; i < SIZE_W; i++) if (r.size[i] && i + 1 > k) k = i + 1;
      if (k > pool_ord) begin
        g.status = ST_TOOBIG;
        return g;
      end
      found = 0; best = 0; best_o = 0; idx = 0;
      while (idx < total) begin
        e = granules[idx];
        o = e[4:0];
        if (!e[6] || o < MIN_BLOCK_ORDER || o > pool_ord) begin
          idx++;
          continue;
        end
        if (e[5] && o >= k && (!found || o < best_o)) begin
          found = 1; best = idx; best_o = o;
        end
        idx += 1 << (o - MIN_BLOCK_ORDER);
      end
      if (!found) begin
        g.status = ST_NOSPACE;
        return g;
      end
      for (j = best_o; j > k; ) begin
        j--;
        granules[best + (1 << (j - MIN_BLOCK_ORDER))] = HEAD_BIT | FREE_BIT | 7'(j);
      end
      granules[best] = HEAD_BIT | 7'(k);
      g.offset = OFF_W'(best << MIN_BLOCK_ORDER);
      g.order = ORD_W'(k);
      live_offs.push_back(best << MIN_BLOCK_ORDER);
      return g;
    end
    if (r.off[MIN_BLOCK_ORDER-1:0] != 0 || (r.off >> MIN_BLOCK_ORDER) >= total) begin
      g.status = ST_BADFREE;
      return g;
    end
    lo = r.off >> MIN_BLOCK_ORDER;
    e = granules[lo];
    k = e[4:0];
    if (!e[6] || e[5] || k < MIN_BLOCK_ORDER || k > pool_ord) begin
      g.status = ST_BADFREE;
      return g;
    end
    foreach (live_offs[i]) if (live_offs[i] == r.off) begin
      live_offs.delete(i);
      break;
    end
    granules[lo] = '0;
    while (k < pool_ord) begin
      bud = lo ^ (1 << (k - MIN_BLOCK_ORDER));
      if (granules[bud] != (HEAD_BIT | FREE_BIT | 7'(k))) break;
      granules[bud] = '0;
      if (bud < lo) lo = bud;
      k++;
    end
    granules[lo] = HEAD_BIT | FREE_BIT | 7'(k);
    g.offset = OFF_W'(lo << MIN_BLOCK_ORDER);
    g.order = ORD_W'(k);
    return g;
  endfunction

  // driver: predict at acceptance so the state follows the block's order
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    cfg_we_i <= cfg_req;
    if (cfg_req) begin
      cfg_wdata_i <= cfg_val;
      cfg_req <= 1'b0;
    end
    if (in_valid_i && !in_stall_o) begin
      expected_grants.push_back(predict_grant(pending_reqs.pop_front()));
      in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    end
    if (in_valid_i && in_stall_o) begin
      // hold the stalled transfer
    end else if (pending_reqs.size() > 0 && in_gap == 0) begin
      in_valid_i <= 1'b1;
      command_i <= pending_reqs[0].cmd;
      request_size_i <= pending_reqs[0].size;
      free_offset_i <= pending_reqs[0].off;
    end else begin
      in_valid_i <= 1'b0;
      if (in_gap > 0) in_gap--;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    grant_t exp_g;
    if (out_valid_o && !out_stall_i) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %h %0d",
                                       status_o, granted_offset_o, granted_order_o);
      end else begin
        exp_g = expected_grants.pop_front();
        if (status_o !== exp_g.status || granted_offset_o !== exp_g.offset ||
            granted_order_o !== exp_g.order) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %h %0d got %0d %h %0d", exp_g.status,
                     exp_g.offset, exp_g.order, status_o, granted_offset_o,
                     granted_order_o);
        end
      end
      out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    end
    if (out_gap > 0) begin
      out_stall_i <= 1'b1;
      out_gap--;
    end else out_stall_i <= 1'b0;
  end

  function automatic alloc_req_t mk_alloc(input int unsigned sz);
    return '{CMD_ALLOC, SIZE_W'(sz), OFF_W'($urandom)};
  endfunction

  function automatic alloc_req_t mk_free(input int unsigned off);
    return '{CMD_FREE, SIZE_W'($urandom), OFF_W'(off)};
  endfunction

  // random size, mostly small so allocations fit
  function automatic int unsigned rand_size();
    int unsigned sh;
    sh = $urandom_range(0, 9) == 0 ? $urandom_range(0, SIZE_W - 1) : $urandom_range(0, 11);
    return $urandom & ((1 << (sh + 1)) - 1);
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_grants.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_pool(input int unsigned v);
    drain();
    cfg_val = ORD_W'(v);
    cfg_req = 1'b1;
    @(posedge clk_i);
    @(posedge clk_i);
    reinit_pool(v);
  endtask

  // random phase; predictor runs at acceptance, live_offs is tracked there
  task automatic random_phase(input int n);
    int unsigned sel, o;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) pending_reqs.push_back(mk_alloc(rand_size()));
      else if (sel < 85) begin
        // wait for predictions so a live offset can be chosen
        while (pending_reqs.size() > 0) @(posedge clk_i);
        if (live_offs.size() > 0)
          o = live_offs[$urandom_range(0, live_offs.size() - 1)];
        else o = 0;
        pending_reqs.push_back(mk_free(o));
      end else if (sel < 92) pending_reqs.push_back(mk_free($urandom & 18'h3ffe0));
      else pending_reqs.push_back(mk_free($urandom));
    end
  endtask

  initial begin
    reinit_pool(POOL_ORDER_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, too big, no space, bad frees, merging
    pending_reqs.push_back(mk_alloc(0));
    pending_reqs.push_back(mk_alloc(1));
    pending_reqs.push_back(mk_alloc(32));
    pending_reqs.push_back(mk_alloc(262144));
    pending_reqs.push_back(mk_alloc(19'h7ffff));
    pending_reqs.push_back(mk_alloc(131071));
    pending_reqs.push_back(mk_alloc(65536));
    pending_reqs.push_back(mk_free(1));
    pending_reqs.push_back(mk_free(18'h3ffe0));
    pending_reqs.push_back(mk_free(64));
    pending_reqs.push_back(mk_free(32));
    pending_reqs.push_back(mk_free(32));
    pending_reqs.push_back(mk_free(0));
    pending_reqs.push_back(mk_free(64));
    pending_reqs.push_back(mk_free(0));
    pending_reqs.push_back(mk_free(131072));
    pending_reqs.push_back(mk_alloc(131072));
    random_phase(250);
    write_pool(13);
    pending_reqs.push_back(mk_alloc(8192));
    pending_reqs.push_back(mk_alloc(4096));
    pending_reqs.push_back(mk_free(8192));
    random_phase(250);
    write_pool(0);
    random_phase(150);
    write_pool(31);
    random_phase(200);
    write_pool(15);
    random_phase(150);
    drain();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
